// File: rtl/serial_set_clock_dawn_dusk_dimmer_core_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the dawn/dusk dimmer core
// Clocked concurrent assertion helpers used by the checker file.
// ----------------------------------------------------------------------------
`ifndef SERIAL_SET_CLOCK_DAWN_DUSK_DIMMER_CORE_MACROS_SVH
`define SERIAL_SET_CLOCK_DAWN_DUSK_DIMMER_CORE_MACROS_SVH

// Checked only while reset is released.
`define SSDD_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every edge, reset included.
`define SSDD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/ssdd_pkg.sv
// ----------------------------------------------------------------------------
// ssdd_pkg
// Shared types and constants of the serial-set clock and dimmer core.
// ----------------------------------------------------------------------------
package ssdd_pkg;

    localparam int unsigned TIME_W  = 7;   // hour, minute and second fields
    localparam int unsigned MOD_W   = 13;  // minutes of the day, up to 99*60+99
    localparam int unsigned DUTY_W  = 16;  // duty counter width
    localparam int unsigned DOUT_W  = 11;  // reported duty width

    localparam logic [1:0] OP_BYTE = 2'd0;
    localparam logic [1:0] OP_TICK = 2'd1;
    localparam logic [1:0] OP_RAMP = 2'd2;

    localparam logic [MOD_W-1:0] SUNRISE_RST = MOD_W'(6 * 60);
    localparam logic [MOD_W-1:0] DUSK_RST    = MOD_W'(20 * 60);

    // Update request from the command parser for one byte.
    typedef struct packed {
        logic              set_time;
        logic              set_sunrise;
        logic              set_dusk;
        logic [TIME_W-1:0] hour;
        logic [TIME_W-1:0] minute;
        logic [TIME_W-1:0] second;
        logic [MOD_W-1:0]  day_minutes;
    } t_parse_upd;

endpackage

// File: rtl/ssdd_parser.sv
// ----------------------------------------------------------------------------
// ssdd_parser
// Command parser for 't' hhmmss, 's' hhmm and 'd' hhmm byte sequences.
// ----------------------------------------------------------------------------
module ssdd_parser
    import ssdd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_en,
    input  logic [7:0] i_rx_byte,
    output t_parse_upd o_upd
);

    typedef enum logic [2:0] {
        PH_IDLE = 3'd0,
        PH_H1   = 3'd1,
        PH_H2   = 3'd2,
        PH_M1   = 3'd3,
        PH_M2   = 3'd4,
        PH_S1   = 3'd5,
        PH_S2   = 3'd6
    } t_phase;

    typedef enum logic [1:0] {
        CMD_NONE = 2'd0,
        CMD_TIME = 2'd1,
        CMD_RISE = 2'd2,
        CMD_DUSK = 2'd3
    } t_cmd;

    t_phase            r_phase, n_phase;
    t_cmd              r_cmd, n_cmd;
    logic [TIME_W-1:0] r_hour, n_hour;
    logic [TIME_W-1:0] r_min, n_min;
    logic [TIME_W-1:0] r_sec, n_sec;

    logic              is_digit;
    logic [TIME_W-1:0] dig;
    logic [TIME_W-1:0] dig_x10;

    assign is_digit = (i_rx_byte >= 8'h30) && (i_rx_byte <= 8'h39);
    assign dig      = is_digit ? TIME_W'(i_rx_byte - 8'h30) : '0;
    assign dig_x10  = (dig << 3) + (dig << 1);

    always_comb begin
        n_phase = r_phase;
        n_cmd   = r_cmd;
        n_hour  = r_hour;
        n_min   = r_min;
        n_sec   = r_sec;
        o_upd   = '0;
        o_upd.hour        = r_hour;
        o_upd.minute      = r_min + dig;
        o_upd.second      = r_sec + dig;
        o_upd.day_minutes = MOD_W'(r_hour) * MOD_W'(60) + MOD_W'(r_min + dig);

        if (!is_digit) begin
            // any non-digit byte restarts; a command letter opens a new command at once
            n_phase = PH_IDLE;
            if (i_rx_byte == 8'h74) begin
                n_cmd   = CMD_TIME;
                n_phase = PH_H1;
            end else if (i_rx_byte == 8'h73) begin
                n_cmd   = CMD_RISE;
                n_phase = PH_H1;
            end else if (i_rx_byte == 8'h64) begin
                n_cmd   = CMD_DUSK;
                n_phase = PH_H1;
            end
        end else begin
            unique case (r_phase)
                PH_IDLE: begin
                end
                PH_H1: begin
                    n_hour  = dig_x10;
                    n_phase = PH_H2;
                end
                PH_H2: begin
                    n_hour  = r_hour + dig;
                    n_phase = PH_M1;
                end
                PH_M1: begin
                    n_min   = dig_x10;
                    n_phase = PH_M2;
                end
                PH_M2: begin
                    n_min = r_min + dig;
                    if (r_cmd == CMD_RISE) begin
                        o_upd.set_sunrise = 1'b1;
                        n_phase           = PH_IDLE;
                    end else if (r_cmd == CMD_DUSK) begin
                        o_upd.set_dusk = 1'b1;
                        n_phase        = PH_IDLE;
                    end else begin
                        n_phase = PH_S1;
                    end
                end
                PH_S1: begin
                    n_sec   = dig_x10;
                    n_phase = PH_S2;
                end
                PH_S2: begin
                    n_sec          = r_sec + dig;
                    o_upd.set_time = 1'b1;
                    o_upd.minute   = r_min;
                    n_phase        = PH_IDLE;
                end
                default: begin
                    n_phase = PH_IDLE;
                end
            endcase
        end

        // drop every request when no byte is being taken
        if (!i_en) begin
            o_upd.set_time    = 1'b0;
            o_upd.set_sunrise = 1'b0;
            o_upd.set_dusk    = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_cmd   <= CMD_NONE;
            r_hour  <= '0;
            r_min   <= '0;
            r_sec   <= '0;
        end else if (i_en) begin
            r_phase <= n_phase;
            r_cmd   <= n_cmd;
            r_hour  <= n_hour;
            r_min   <= n_min;
            r_sec   <= n_sec;
        end
    end

endmodule

// File: rtl/serial_set_clock_dawn_dusk_dimmer_core.sv
// ----------------------------------------------------------------------------
// serial_set_clock_dawn_dusk_dimmer_core
// Serial-set wall clock with a dawn/dusk dimmer ramp.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_stall) carries one item per transfer:
//   opcode 0 is a received byte for the command parser, 1 a half-second
//   timer tick, 2 a duty ramp step; opcode 3 changes nothing.
//   Output channel (o_out_valid / i_out_stall) returns one item per input
//   item: the clock, its valid flag and the duty value after that item.
//   An accepted item sits in the input register, then the state and result
//   registers load together when it fires, and o_out_valid rises with them.
//   Throughput is one item per cycle while the output is not stalled; the
//   input register lets a new item in while a result still waits to be
//   taken.
//   While i_out_stall is high the result holds, and o_in_stall rises once
//   the input register is also full.
//   Synchronous reset clears both channels, the parser, the clock (not
//   valid), sets sunrise to 06:00, dusk to 20:00 and the duty to DUTY_MAX.
// ----------------------------------------------------------------------------
module serial_set_clock_dawn_dusk_dimmer_core
    import ssdd_pkg::*;
#(
    parameter int unsigned DUTY_MAX = 1024
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [1:0]        i_opcode,
    input  logic [7:0]        i_rx_byte,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic [TIME_W-1:0] o_clock_hour,
    output logic [TIME_W-1:0] o_clock_minute,
    output logic [TIME_W-1:0] o_clock_second,
    output logic              o_clock_valid,
    output logic [DOUT_W-1:0] o_duty_value
);

    localparam logic [DUTY_W-1:0] DUTY_TOP = DUTY_W'(DUTY_MAX);

    logic              r_in_valid;
    logic [1:0]        r_in_opcode;
    logic [7:0]        r_in_byte;
    logic              r_out_valid;

    logic [TIME_W-1:0] r_hour, n_hour;
    logic [TIME_W-1:0] r_min, n_min;
    logic [TIME_W-1:0] r_sec, n_sec;
    logic              r_set, n_set;
    logic              r_half, n_half;
    logic [MOD_W-1:0]  r_sunrise, n_sunrise;
    logic [MOD_W-1:0]  r_dusk, n_dusk;
    logic [DUTY_W-1:0] r_duty, n_duty;

    logic              advance;
    logic              fire;
    logic              in_take;
    t_parse_upd        upd;

    logic [TIME_W-1:0] sec_inc, min_inc, hour_inc;
    logic [MOD_W-1:0]  now_min;
    logic              day_window;
    logic [DUTY_W-1:0] duty_target;

    assign advance    = !r_out_valid || !i_out_stall;
    assign fire       = r_in_valid && advance;
    assign o_in_stall = r_in_valid && !advance;
    assign in_take    = i_in_valid && !o_in_stall;

    ssdd_parser u_parser (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (fire && (r_in_opcode == OP_BYTE)),
        .i_rx_byte (r_in_byte),
        .o_upd     (upd)
    );

    assign sec_inc  = r_sec + TIME_W'(1);
    assign min_inc  = r_min + TIME_W'(1);
    assign hour_inc = r_hour + TIME_W'(1);

    assign now_min    = MOD_W'(r_hour) * MOD_W'(60) + MOD_W'(r_min);
    assign day_window = (r_sunrise < r_dusk) && (now_min >= r_sunrise)
                        && (now_min < r_dusk);
    assign duty_target = day_window ? '0 : DUTY_TOP;

    always_comb begin
        n_hour    = r_hour;
        n_min     = r_min;
        n_sec     = r_sec;
        n_set     = r_set;
        n_half    = r_half;
        n_sunrise = r_sunrise;
        n_dusk    = r_dusk;
        n_duty    = r_duty;

        case (r_in_opcode)
            OP_BYTE: begin
                if (upd.set_time) begin
                    n_hour = upd.hour;
                    n_min  = upd.minute;
                    n_sec  = upd.second;
                    n_set  = 1'b1;
                end
                if (upd.set_sunrise) begin
                    n_sunrise = upd.day_minutes;
                end
                if (upd.set_dusk) begin
                    n_dusk = upd.day_minutes;
                end
            end
            OP_TICK: begin
                n_half = !r_half;
                // advance once per two half-second ticks, carrying upward
                if (r_set && r_half) begin
                    n_sec = sec_inc;
                    if (sec_inc >= TIME_W'(60)) begin
                        n_sec = '0;
                        n_min = min_inc;
                        if (min_inc >= TIME_W'(60)) begin
                            n_min  = '0;
                            n_hour = (hour_inc >= TIME_W'(24)) ? '0 : hour_inc;
                        end
                    end
                end
            end
            OP_RAMP: begin
                if (r_set) begin
                    if (r_duty > duty_target) begin
                        n_duty = r_duty - DUTY_W'(1);
                    end else if (r_duty < duty_target) begin
                        n_duty = r_duty + DUTY_W'(1);
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_opcode <= i_opcode;
            r_in_byte   <= i_rx_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_hour      <= '0;
            r_min       <= '0;
            r_sec       <= '0;
            r_set       <= 1'b0;
            r_half      <= 1'b0;
            r_sunrise   <= SUNRISE_RST;
            r_dusk      <= DUSK_RST;
            r_duty      <= DUTY_TOP;
        end else begin
            if (in_take) begin
                r_in_valid <= 1'b1;
            end else if (fire) begin
                r_in_valid <= 1'b0;
            end

            if (fire) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            // state doubles as the result register: it only moves on fire
            if (fire) begin
                r_hour    <= n_hour;
                r_min     <= n_min;
                r_sec     <= n_sec;
                r_set     <= n_set;
                r_half    <= n_half;
                r_sunrise <= n_sunrise;
                r_dusk    <= n_dusk;
                r_duty    <= n_duty;
            end
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_clock_hour   = r_hour;
    assign o_clock_minute = r_min;
    assign o_clock_second = r_sec;
    assign o_clock_valid  = r_set;
    assign o_duty_value   = r_duty[DOUT_W-1:0];

endmodule

// File: rtl/ssdd_checker.sv
// ----------------------------------------------------------------------------
// ssdd_checker
// Port-level assertions for the dawn/dusk dimmer core, bound to the top.
// ----------------------------------------------------------------------------
`include "serial_set_clock_dawn_dusk_dimmer_core_macros.svh"

module ssdd_checker
    import ssdd_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              o_in_stall,
    input logic              o_out_valid,
    input logic              i_out_stall,
    input logic [TIME_W-1:0] o_clock_hour,
    input logic [TIME_W-1:0] o_clock_minute,
    input logic [TIME_W-1:0] o_clock_second,
    input logic              o_clock_valid,
    input logic [DOUT_W-1:0] o_duty_value
);

    `SSDD_ASSERT_ALWAYS(a_reset_empty, i_clk, !i_rst_n |=> !o_out_valid && !o_in_stall, "channels not empty after reset")

    `SSDD_ASSERT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall |=> o_out_valid && $stable(o_clock_second) && $stable(o_duty_value), "stalled result changed")

    `SSDD_ASSERT(a_stall_needs_full, i_clk, i_rst_n, o_in_stall |-> o_out_valid && i_out_stall, "input stalled while output can move")

    `SSDD_ASSERT(a_valid_sticks, i_clk, i_rst_n, o_out_valid && o_clock_valid |=> o_clock_valid, "clock valid flag dropped")

    `SSDD_ASSERT(a_time_range, i_clk, i_rst_n, o_out_valid |-> o_clock_hour <= TIME_W'(99) && o_clock_minute <= TIME_W'(99) && o_clock_second <= TIME_W'(99), "time field out of range")

endmodule

bind serial_set_clock_dawn_dusk_dimmer_core ssdd_checker u_ssdd_checker (.*);
